[sv/cpp_pkg.sv]
// shared types and constants for the closest point on polyline block
package cpp_pkg;
	localparam int CB = 24;
	localparam int TFB = 16;
	localparam int IB = 16;
	localparam int DW = 2 * CB + 3;
	localparam int MW = CB + 2;
	localparam int PW = 2 * MW;
	localparam int CNTW = $clog2(TFB);

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_PRE, ST_DIV,
		ST_T1, ST_T2, ST_T3, ST_E1, ST_E2, ST_E3, ST_CMP, ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		MS_NONE, MS_DXDX, MS_DYDY, MS_WXDX, MS_WYDY, MS_TDX, MS_TDY, MS_EXEX
	} mul_sel_t;

	typedef struct packed {
		logic accept;
		mul_sel_t mul;
		logic mul_ey;
		logic len_ld;
		logic len_acc;
		logic dot_ld;
		logic dot_acc;
		logic t_zero;
		logic t_one;
		logic div_init;
		logic div_step;
		logic cx_ld;
		logic cy_ld;
		logic ey_ld;
		logic dist_ld;
		logic dist_acc;
		logic compare;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic dot_nonpos;
		logic dot_ge_len;
		logic last_q;
		logic out_busy;
	} status_t;
endpackage

[sv/cpp_if.sv]
// request channel interfaces for vertices and results
interface cpp_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [cpp_pkg::CB-1:0] coord_x;
	logic signed [cpp_pkg::CB-1:0] coord_y;
	logic last;
	modport source(output valid, opcode, coord_x, coord_y, last, input ready);
	modport sink(input valid, opcode, coord_x, coord_y, last, output ready);
endinterface

interface cpp_out_if;
	logic valid;
	logic ready;
	logic signed [cpp_pkg::CB-1:0] close_x;
	logic signed [cpp_pkg::CB-1:0] close_y;
	logic [cpp_pkg::IB-1:0] segment_index;
	modport source(output valid, close_x, close_y, segment_index, input ready);
	modport sink(input valid, close_x, close_y, segment_index, output ready);
endinterface

[sv/cpp_ctrl.sv]
// sequencer for projection, division and distance steps
module cpp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_opcode,
	input  logic             item_last,
	input  cpp_pkg::status_t sts,
	output logic             item_ready,
	output cpp_pkg::cmd_t    cmd
);
	import cpp_pkg::*;

	state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul = MS_NONE;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (item_opcode == OP_VERTEX) begin
						if (sts.have_prev) state_d = ST_M1;
						else if (item_last) state_d = ST_EMIT;
					end
				end
			end
			ST_M1: begin
				cmd.mul = MS_DXDX;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.mul = MS_DYDY;
				cmd.len_ld = 1'b1;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.mul = MS_WXDX;
				cmd.len_acc = 1'b1;
				state_d = ST_M4;
			end
			ST_M4: begin
				cmd.mul = MS_WYDY;
				cmd.dot_ld = 1'b1;
				state_d = ST_M5;
			end
			ST_M5: begin
				cmd.dot_acc = 1'b1;
				state_d = ST_PRE;
			end
			ST_PRE: begin
				if (sts.dot_nonpos) begin
					cmd.t_zero = 1'b1;
					state_d = ST_T1;
				end else if (sts.dot_ge_len) begin
					cmd.t_one = 1'b1;
					state_d = ST_T1;
				end else begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNTW'(TFB - 1)) state_d = ST_T1;
			end
			ST_T1: begin
				cmd.mul = MS_TDX;
				state_d = ST_T2;
			end
			ST_T2: begin
				cmd.mul = MS_TDY;
				cmd.cx_ld = 1'b1;
				state_d = ST_T3;
			end
			ST_T3: begin
				cmd.cy_ld = 1'b1;
				state_d = ST_E1;
			end
			ST_E1: begin
				cmd.mul = MS_EXEX;
				cmd.ey_ld = 1'b1;
				state_d = ST_E2;
			end
			ST_E2: begin
				cmd.mul = MS_EXEX;
				cmd.mul_ey = 1'b1;
				cmd.dist_ld = 1'b1;
				state_d = ST_E3;
			end
			ST_E3: begin
				cmd.dist_acc = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d = sts.last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[sv/cpp_dp.sv]
// datapath with shared multiplier, restoring divider and best point registers
module cpp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cpp_pkg::cmd_t               cmd,
	input  logic                        item_opcode,
	input  logic signed [cpp_pkg::CB-1:0] item_x,
	input  logic signed [cpp_pkg::CB-1:0] item_y,
	input  logic                        item_last,
	input  logic                        out_ready,
	output cpp_pkg::status_t            sts,
	output logic                        out_valid,
	output logic signed [cpp_pkg::CB-1:0] out_x,
	output logic signed [cpp_pkg::CB-1:0] out_y,
	output logic [cpp_pkg::IB-1:0]      out_index
);
	import cpp_pkg::*;

	logic signed [CB-1:0] qx_q, qy_q, px_q, py_q, ax_q, ay_q, cx_q, cy_q;
	logic signed [CB:0] dx_q, dy_q, wx_q, wy_q, ex_q, ey_q;
	logic signed [PW-1:0] prod_q, dot_q;
	logic [DW-1:0] len_q, dist_q, best_dist_q;
	logic [DW:0] rem_q, rem_sh;
	logic [TFB:0] t_q;
	logic signed [CB-1:0] best_x_q, best_y_q;
	logic [IB-1:0] best_idx_q, seg_cnt_q;
	logic have_prev_q, last_q, out_valid_q, clear;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] rnd;
	logic signed [CB-1:0] proj;

	always_comb begin
		case (cmd.mul)
			MS_DXDX: begin mul_a = MW'(dx_q); mul_b = MW'(dx_q); end
			MS_DYDY: begin mul_a = MW'(dy_q); mul_b = MW'(dy_q); end
			MS_WXDX: begin mul_a = MW'(wx_q); mul_b = MW'(dx_q); end
			MS_WYDY: begin mul_a = MW'(wy_q); mul_b = MW'(dy_q); end
			MS_TDX: begin mul_a = $signed(MW'(t_q)); mul_b = MW'(dx_q); end
			MS_TDY: begin mul_a = $signed(MW'(t_q)); mul_b = MW'(dy_q); end
			MS_EXEX: begin
				mul_a = cmd.mul_ey ? MW'(ey_q) : MW'(ex_q);
				mul_b = mul_a;
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign rnd = (prod_q + (PW'(1) <<< (TFB - 1))) >>> TFB;
	assign proj = rnd[CB-1:0];
	assign rem_sh = {rem_q[DW-1:0], 1'b0};
	assign clear = (cmd.accept && item_opcode == OP_QUERY) || cmd.emit;

	assign sts = '{
		have_prev: have_prev_q,
		dot_nonpos: dot_q[PW-1] || (dot_q == '0),
		dot_ge_len: $unsigned(dot_q) >= PW'(len_q),
		last_q: last_q,
		out_busy: out_valid_q && !out_ready
	};

	always_ff @(posedge clk) begin
		if (cmd.mul != MS_NONE) prod_q <= mul_a * mul_b;
		if (cmd.len_ld) len_q <= prod_q[DW-1:0];
		if (cmd.len_acc) len_q <= len_q + prod_q[DW-1:0];
		if (cmd.dot_ld) dot_q <= prod_q;
		if (cmd.dot_acc) dot_q <= dot_q + prod_q;
		if (cmd.t_zero) t_q <= '0;
		if (cmd.t_one) t_q <= (TFB+1)'(1) << TFB;
		if (cmd.div_init) begin
			t_q <= '0;
			rem_q <= (DW+1)'($unsigned(dot_q));
		end
		if (cmd.div_step) begin
			if (rem_sh >= {1'b0, len_q}) begin
				rem_q <= rem_sh - {1'b0, len_q};
				t_q <= {t_q[TFB-1:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				t_q <= {t_q[TFB-1:0], 1'b0};
			end
		end
		if (cmd.cx_ld) cx_q <= ax_q + proj;
		if (cmd.cy_ld) begin
			cy_q <= ay_q + proj;
			ex_q <= {qx_q[CB-1], qx_q} - {cx_q[CB-1], cx_q};
		end
		if (cmd.ey_ld) ey_q <= {qy_q[CB-1], qy_q} - {cy_q[CB-1], cy_q};
		if (cmd.dist_ld) dist_q <= prod_q[DW-1:0];
		if (cmd.dist_acc) dist_q <= dist_q + prod_q[DW-1:0];
		if (cmd.accept && item_opcode == OP_VERTEX) begin
			ax_q <= px_q;
			ay_q <= py_q;
			dx_q <= {item_x[CB-1], item_x} - {px_q[CB-1], px_q};
			dy_q <= {item_y[CB-1], item_y} - {py_q[CB-1], py_q};
			wx_q <= {qx_q[CB-1], qx_q} - {px_q[CB-1], px_q};
			wy_q <= {qy_q[CB-1], qy_q} - {py_q[CB-1], py_q};
			last_q <= item_last;
		end
		if (cmd.emit) begin
			out_x <= best_x_q;
			out_y <= best_y_q;
			out_index <= best_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qy_q <= '0;
			px_q <= '0;
			py_q <= '0;
			have_prev_q <= 1'b0;
			seg_cnt_q <= '0;
			best_dist_q <= '1;
			best_x_q <= '0;
			best_y_q <= '0;
			best_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (clear) begin
				have_prev_q <= 1'b0;
				seg_cnt_q <= '0;
				best_dist_q <= '1;
				best_x_q <= '0;
				best_y_q <= '0;
				best_idx_q <= '0;
				if (cmd.accept) begin
					qx_q <= item_x;
					qy_q <= item_y;
				end
			end else if (cmd.accept) begin
				px_q <= item_x;
				py_q <= item_y;
				have_prev_q <= 1'b1;
				if (!have_prev_q && item_last) begin
					best_x_q <= item_x;
					best_y_q <= item_y;
					best_idx_q <= '0;
				end
			end
			if (cmd.compare) begin
				if (dist_q < best_dist_q) begin
					best_dist_q <= dist_q;
					best_x_q <= cx_q;
					best_y_q <= cy_q;
					best_idx_q <= seg_cnt_q;
				end
				if (seg_cnt_q != '1) seg_cnt_q <= seg_cnt_q + 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

[sv/closest_point_on_polyline.sv]
// top level of the closest point on polyline block
// usage:
// item channel carries requests: opcode 0 loads the query point and
// clears the polyline, opcode 1 brings a vertex, last marks the final one
// result channel carries close_x, close_y and segment_index, one result
// per polyline, after its last vertex
// a vertex that closes a segment holds item ready low until its segment
// is scored, and for the last one until its result is loaded; the wait is
// set by the 16-step restoring divider for the projection parameter, unused
// when it is clamped to an end, and by the single shared 26x26 multiplier
// a query load, or a first vertex that is not also the last, leaves the block idle
// the result register is loaded in the emit state that follows the scoring of
// the last segment; a lone last vertex goes from acceptance straight to that state
// while a result waits unread, the block keeps taking and scoring vertices
// and only holds in its emit state until the result register is free
// reset clears the query, previous vertex and best point to zero and the
// best distance to all ones
module closest_point_on_polyline (
	input logic clk,
	input logic arst_n,
	cpp_in_if.sink item,
	cpp_out_if.source result
);
	import cpp_pkg::*;

	cmd_t cmd;
	status_t sts;

	cpp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_opcode(item.opcode),
		.item_last(item.last),
		.sts(sts),
		.item_ready(item.ready),
		.cmd(cmd)
	);

	cpp_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item_opcode(item.opcode),
		.item_x(item.coord_x),
		.item_y(item.coord_y),
		.item_last(item.last),
		.out_ready(result.ready),
		.sts(sts),
		.out_valid(result.valid),
		.out_x(result.close_x),
		.out_y(result.close_y),
		.out_index(result.segment_index)
	);
endmodule

[sv/cpp_checker.sv]
// port level checks for the closest point on polyline block
module cpp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_opcode,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic [cpp_pkg::IB-1:0] out_index
);
	import cpp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_index))
		else $error("segment index changed while stalled");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result raised right after a request");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == OP_VERTEX && in_last |=> !in_ready)
		else $error("ready after last vertex without emit");
endmodule

bind closest_point_on_polyline cpp_checker u_cpp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.in_opcode(item.opcode),
	.in_last(item.last),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_index(result.segment_index)
);
